[rtl/reno_congestion_window_control_defines.svh]
// Assertion macros shared by the congestion window controller RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef RENO_CONGESTION_WINDOW_CONTROL_DEFINES_SVH
`define RENO_CONGESTION_WINDOW_CONTROL_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RCWC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define RCWC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/reno_cwc_pkg.sv]
// Shared types and constants of the Reno congestion window controller.
// No dependencies; used by the interfaces, the top level and the bench.
`default_nettype none

package reno_cwc_pkg;

  localparam int SEQ_BITS        = 16;
  localparam int WINDOW_BITS     = 24;
  localparam int MSS_BITS        = 16;
  localparam int MSS3_BITS       = MSS_BITS + 2;
  localparam int THRESH_CFG_BITS = 24;
  localparam int COUNT_BITS      = 16;
  localparam int TIMER_BITS      = 32;
  localparam int REG_DATA_BITS   = 32;
  localparam int REG_ADDR_BITS   = 4;

  localparam logic [MSS_BITS-1:0]        MSS_RESET     = 16'd1024;
  localparam logic [THRESH_CFG_BITS-1:0] THRESH_RESET  = 24'd65536;
  localparam logic [COUNT_BITS-1:0]      COUNT_RESET   = 16'd0;
  localparam logic [TIMER_BITS-1:0]      TIMEOUT_RESET = 32'd1000;

  localparam logic [1:0] DUP_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_POLL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_SLOW_START = 2'd0,
    PH_AVOIDANCE  = 2'd1,
    PH_RECOVERY   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_SEGMENT_SIZE  = 2'd0,
    REG_INIT_THRESH   = 2'd1,
    REG_SEGMENT_COUNT = 2'd2,
    REG_TIMEOUT       = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INC,
    ST_DIV_QUOT,
    ST_DIV_POLL,
    ST_EMIT
  } ctl_state_e;

endpackage

`default_nettype wire

[rtl/reno_cwc_if.sv]
// Valid/ready channel interfaces for input and result transactions.
// Depends on reno_cwc_pkg for widths and the operation code type.
`default_nettype none

interface reno_cwc_in_if #(
  parameter int SeqBits = reno_cwc_pkg::SEQ_BITS
);
  logic                 valid;
  logic                 ready;
  reno_cwc_pkg::op_e    op;
  logic [SeqBits-1:0]   ack_number;
  logic                 ack_good;

  modport source (output valid, output op, output ack_number, output ack_good,
                  input ready);
  modport sink   (input valid, input op, input ack_number, input ack_good,
                  output ready);
endinterface

interface reno_cwc_out_if #(
  parameter int SeqBits    = reno_cwc_pkg::SEQ_BITS,
  parameter int WindowBits = reno_cwc_pkg::WINDOW_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  send_valid;
  logic [SeqBits-1:0]    first_segment;
  logic [SeqBits-1:0]    last_segment;
  logic                  is_resend;
  logic                  transfer_done;
  logic [WindowBits-1:0] window_bytes;
  logic [WindowBits-1:0] threshold_bytes;
  logic [1:0]            phase;

  modport source (output valid, output send_valid, output first_segment,
                  output last_segment, output is_resend, output transfer_done,
                  output window_bytes, output threshold_bytes, output phase,
                  input ready);
  modport sink   (input valid, input send_valid, input first_segment,
                  input last_segment, input is_resend, input transfer_done,
                  input window_bytes, input threshold_bytes, input phase,
                  output ready);
endinterface

`default_nettype wire

[rtl/reno_cwc_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Standalone; shared by the window controller for cwnd/MSS and MSS/N.
`default_nettype none

module reno_cwc_div #(
  parameter int DividendBits = 24,
  parameter int DivisorBits  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DividendBits-1:0] dividend_i,
  input  logic [DivisorBits-1:0]  divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [DividendBits-1:0] quotient_o
);

  localparam int CntBits = $clog2(DividendBits + 1);

  logic [DivisorBits-1:0]  rem_q, rem_d;
  logic [DividendBits-1:0] quo_q, quo_d;
  logic [DivisorBits-1:0]  dvs_q, dvs_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DivisorBits:0]    shifted;
  logic [DivisorBits:0]    diff;
  logic                    fits;

  assign shifted = {rem_q, quo_q[DividendBits-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntBits'(DividendBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DivisorBits-1:0] : shifted[DivisorBits-1:0];
      quo_d = {quo_q[DividendBits-2:0], fits};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/reno_congestion_window_control.sv]
// Reno congestion window controller: start, ACK, tick, send-poll sequencer.
// Depends on reno_cwc_pkg, reno_cwc_if, reno_cwc_div and the defines header.
// Start, tick and an ACK that is not new go straight to ST_EMIT after acceptance; new ACK and
// poll first take one divider pass, new ACK in avoidance two (ST_DIV_INC, then ST_DIV_QUOT),
// on the serial divider (one quotient bit a cycle); ST_EMIT registers the result once out is free.
// One transaction in flight; asynchronous active-low reset, no clearing pass.
`default_nettype none
`include "reno_congestion_window_control_defines.svh"

module reno_congestion_window_control #(
  parameter int SeqBits    = reno_cwc_pkg::SEQ_BITS,
  parameter int WindowBits = reno_cwc_pkg::WINDOW_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  reno_cwc_in_if.sink                             in_i,
  reno_cwc_out_if.source                          out_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [reno_cwc_pkg::REG_ADDR_BITS-1:0]  paddr,
  input  logic [reno_cwc_pkg::REG_DATA_BITS-1:0]  pwdata,
  output logic [reno_cwc_pkg::REG_DATA_BITS-1:0]  prdata,
  output logic                                    pready
);

  import reno_cwc_pkg::*;

  localparam int DivW = (MSS_BITS > SeqBits) ? MSS_BITS : SeqBits;
  localparam int LnW  = ((SeqBits > COUNT_BITS) ? SeqBits : COUNT_BITS) + 1;
  localparam int QW   = (WindowBits > SeqBits) ? WindowBits : SeqBits;
  localparam int SW   = ((WindowBits > MSS3_BITS) ? WindowBits : MSS3_BITS) + 1;
  localparam int TW   = (WindowBits > THRESH_CFG_BITS) ? WindowBits : THRESH_CFG_BITS;
  localparam int TopW = SeqBits + 1;

  // Configuration registers
  logic [MSS_BITS-1:0]        mss_cfg_q;
  logic [THRESH_CFG_BITS-1:0] thresh_cfg_q;
  logic [COUNT_BITS-1:0]      count_cfg_q;
  logic [TIMER_BITS-1:0]      timeout_q;
  logic                       cfg_write;
  reg_idx_e                   cfg_idx;

  // Controller state
  ctl_state_e             state_q, state_d;
  logic [WindowBits-1:0]  window_q, window_d;
  logic [WindowBits-1:0]  threshold_q, threshold_d;
  logic [1:0]             dup_q, dup_d;
  phase_e                 phase_q, phase_d;
  logic [SeqBits-1:0]     base_q, base_d;
  logic [SeqBits-1:0]     next_q, next_d;
  logic [SeqBits-1:0]     wseg_q, wseg_d;
  logic                   timer_run_q, timer_run_d;
  logic [TIMER_BITS-1:0]  timer_q, timer_d;

  // Pending range
  logic                   rng_valid_q, rng_valid_d;
  logic [SeqBits-1:0]     rng_first_q, rng_first_d;
  logic [SeqBits-1:0]     rng_last_q, rng_last_d;
  logic                   rng_resend_q, rng_resend_d;
  logic                   resend_all;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic                   send_q;
  logic [SeqBits-1:0]     first_q;
  logic [SeqBits-1:0]     last_q;
  logic                   resend_q;
  logic                   done_q;
  logic [WindowBits-1:0]  win_out_q;
  logic [WindowBits-1:0]  thr_out_q;
  phase_e                 phase_out_q;

  // Divider
  logic                   div_start;
  logic                   inc_sel;
  logic [WindowBits-1:0]  div_dividend;
  logic [DivW-1:0]        div_divisor;
  logic                   div_busy;
  logic                   div_done;
  logic [WindowBits-1:0]  div_quo;

  // Derived values
  logic                   in_fire;
  logic [MSS_BITS-1:0]    mss_eff;
  logic [WindowBits-1:0]  mss_win;
  logic [WindowBits-1:0]  win_max;
  logic [TW-1:0]          thr_cfg_ext;
  logic [WindowBits-1:0]  thr_init;
  logic [LnW-1:0]         cnt_wide;
  logic [LnW-1:0]         lim_wide;
  logic [SeqBits-1:0]     last_num;
  logic [SeqBits-1:0]     last_p1;
  logic [QW-1:0]          q_ext;
  logic [QW-1:0]          seqmax_ext;
  logic [QW-1:0]          q_clamp;
  logic [SeqBits-1:0]     ws_from_div;
  logic [SeqBits-1:0]     wseg_div;
  logic [WindowBits-1:0]  thr_half;
  logic [MSS3_BITS-1:0]   three_mss;
  logic [SW-1:0]          dup_sum;
  logic [WindowBits-1:0]  window_dup;
  logic [TopW-1:0]        top_raw;
  logic [TopW-1:0]        top_cap;
  logic [TopW-1:0]        top_sel;
  logic [SeqBits-1:0]     ack_p1;
  logic [1:0]             dup_inc;
  logic [TIMER_BITS-1:0]  tick_inc;

  function automatic logic [WindowBits-1:0] sat_add(input logic [WindowBits-1:0] a,
                                                    input logic [WindowBits-1:0] b);
    logic [WindowBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WindowBits] ? {WindowBits{1'b1}} : s[WindowBits-1:0];
  endfunction

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_cfg_q    <= MSS_RESET;
      thresh_cfg_q <= THRESH_RESET;
      count_cfg_q  <= COUNT_RESET;
      timeout_q    <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_SEGMENT_SIZE:  mss_cfg_q    <= pwdata[MSS_BITS-1:0];
        REG_INIT_THRESH:   thresh_cfg_q <= pwdata[THRESH_CFG_BITS-1:0];
        REG_SEGMENT_COUNT: count_cfg_q  <= pwdata[COUNT_BITS-1:0];
        REG_TIMEOUT:       timeout_q    <= pwdata[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEGMENT_SIZE:  prdata = REG_DATA_BITS'(mss_cfg_q);
      REG_INIT_THRESH:   prdata = REG_DATA_BITS'(thresh_cfg_q);
      REG_SEGMENT_COUNT: prdata = REG_DATA_BITS'(count_cfg_q);
      REG_TIMEOUT:       prdata = REG_DATA_BITS'(timeout_q);
      default:           prdata = '0;
    endcase
  end

  // Derived values
  assign in_fire  = in_i.valid && in_i.ready;
  assign mss_eff  = (mss_cfg_q == '0) ? MSS_BITS'(1) : mss_cfg_q;
  assign mss_win  = WindowBits'(mss_eff);
  assign win_max  = {WindowBits{1'b1}};

  assign thr_cfg_ext = TW'(thresh_cfg_q);
  assign thr_init    = (thr_cfg_ext > TW'(win_max)) ? win_max : WindowBits'(thr_cfg_ext);

  assign cnt_wide = LnW'(count_cfg_q);
  assign lim_wide = LnW'({SeqBits{1'b1}}) - LnW'(1);
  assign last_num = (cnt_wide > lim_wide) ? SeqBits'(lim_wide) : SeqBits'(cnt_wide);
  assign last_p1  = last_num + SeqBits'(1);

  // window / MSS: zero counts as one segment, clamped to the sequence range
  assign q_ext       = QW'(div_quo);
  assign seqmax_ext  = QW'({SeqBits{1'b1}});
  assign q_clamp     = (q_ext == '0) ? QW'(1) : ((q_ext > seqmax_ext) ? seqmax_ext : q_ext);
  assign ws_from_div = q_clamp[SeqBits-1:0];
  assign wseg_div    = (wseg_q == '0) ? SeqBits'(1) : wseg_q;

  assign thr_half   = window_q >> 1;
  assign three_mss  = {2'b00, mss_eff} + {1'b0, mss_eff, 1'b0};
  assign dup_sum    = SW'(thr_half) + SW'(three_mss);
  assign window_dup = (dup_sum > SW'(win_max)) ? win_max : dup_sum[WindowBits-1:0];

  assign top_raw = TopW'(base_q) + TopW'(ws_from_div) - TopW'(1);
  assign top_cap = TopW'(last_num);
  assign top_sel = (top_raw > top_cap) ? top_cap : top_raw;

  assign ack_p1   = in_i.ack_number + SeqBits'(1);
  assign dup_inc  = dup_q + 2'd1;
  assign tick_inc = (timer_q == {TIMER_BITS{1'b1}}) ? timer_q : timer_q + TIMER_BITS'(1);

  assign in_i.ready = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    window_d     = window_q;
    threshold_d  = threshold_q;
    dup_d        = dup_q;
    phase_d      = phase_q;
    base_d       = base_q;
    next_d       = next_q;
    wseg_d       = wseg_q;
    timer_run_d  = timer_run_q;
    timer_d      = timer_q;
    rng_valid_d  = rng_valid_q;
    rng_first_d  = rng_first_q;
    rng_last_d   = rng_last_q;
    rng_resend_d = rng_resend_q;
    resend_all   = 1'b0;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    div_start    = 1'b0;
    inc_sel      = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rng_valid_d  = 1'b0;
          rng_resend_d = 1'b0;
          state_d      = ST_EMIT;
          unique case (in_i.op)
            OP_START: begin
              window_d    = mss_win;
              threshold_d = thr_init;
              dup_d       = '0;
              phase_d     = PH_SLOW_START;
              base_d      = SeqBits'(1);
              next_d      = SeqBits'(1);
              wseg_d      = SeqBits'(1);
              timer_run_d = 1'b0;
              timer_d     = '0;
            end
            OP_ACK: begin
              if (in_i.ack_good && (in_i.ack_number >= base_q) &&
                  (in_i.ack_number < next_q)) begin
                dup_d       = '0;
                base_d      = ack_p1;
                timer_d     = '0;
                timer_run_d = (ack_p1 != next_q);
                div_start   = 1'b1;
                case (phase_q)
                  PH_AVOIDANCE: begin
                    inc_sel = 1'b1;
                    state_d = ST_DIV_INC;
                  end
                  PH_RECOVERY: begin
                    window_d = threshold_q;
                    phase_d  = PH_AVOIDANCE;
                    state_d  = ST_DIV_QUOT;
                  end
                  default: begin
                    window_d = sat_add(window_q, mss_win);
                    phase_d  = (window_d >= threshold_q) ? PH_AVOIDANCE : PH_SLOW_START;
                    state_d  = ST_DIV_QUOT;
                  end
                endcase
              end else if (in_i.ack_good && (in_i.ack_number < base_q)) begin
                if (phase_q == PH_RECOVERY) begin
                  window_d = sat_add(window_q, mss_win);
                end else if (dup_q < DUP_LIMIT) begin
                  dup_d = dup_inc;
                  if (dup_inc == DUP_LIMIT) begin
                    threshold_d = thr_half;
                    window_d    = window_dup;
                    phase_d     = PH_RECOVERY;
                    timer_d     = '0;
                    resend_all  = 1'b1;
                  end
                end
              end
            end
            OP_TICK: begin
              if (timer_run_q) begin
                timer_d = tick_inc;
                if (tick_inc >= timeout_q) begin
                  threshold_d = thr_half;
                  window_d    = mss_win;
                  dup_d       = '0;
                  phase_d     = PH_SLOW_START;
                  timer_d     = '0;
                  resend_all  = 1'b1;
                end
              end
            end
            OP_POLL: begin
              div_start = 1'b1;
              state_d   = ST_DIV_POLL;
            end
            default: ;
          endcase
        end
      end
      ST_DIV_INC: begin
        if (div_done) begin
          window_d  = sat_add(window_q, div_quo);
          div_start = 1'b1;
          state_d   = ST_DIV_QUOT;
        end
      end
      ST_DIV_QUOT: begin
        if (div_done) begin
          wseg_d  = ws_from_div;
          state_d = ST_EMIT;
        end
      end
      ST_DIV_POLL: begin
        if (div_done) begin
          wseg_d  = ws_from_div;
          state_d = ST_EMIT;
          if (TopW'(next_q) <= top_sel) begin
            rng_valid_d = 1'b1;
            rng_first_d = next_q;
            rng_last_d  = top_sel[SeqBits-1:0];
            if (!timer_run_q && (base_q == next_q)) begin
              timer_run_d = 1'b1;
              timer_d     = '0;
            end
            next_d = top_sel[SeqBits-1:0] + SeqBits'(1);
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // go-back-N: resend everything in flight
    if (resend_all) begin
      rng_valid_d  = (base_q < next_q);
      rng_first_d  = base_q;
      rng_last_d   = next_q - SeqBits'(1);
      rng_resend_d = 1'b1;
    end

    div_dividend = inc_sel ? mss_win : window_d;
    div_divisor  = inc_sel ? DivW'(wseg_div) : DivW'(mss_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_q     <= '0;
      threshold_q  <= '0;
      dup_q        <= '0;
      phase_q      <= PH_SLOW_START;
      base_q       <= SeqBits'(1);
      next_q       <= SeqBits'(1);
      wseg_q       <= SeqBits'(1);
      timer_run_q  <= 1'b0;
      timer_q      <= '0;
      rng_valid_q  <= 1'b0;
      rng_resend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      window_q     <= window_d;
      threshold_q  <= threshold_d;
      dup_q        <= dup_d;
      phase_q      <= phase_d;
      base_q       <= base_d;
      next_q       <= next_d;
      wseg_q       <= wseg_d;
      timer_run_q  <= timer_run_d;
      timer_q      <= timer_d;
      rng_valid_q  <= rng_valid_d;
      rng_resend_q <= rng_resend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rng_first_q <= rng_first_d;
    rng_last_q  <= rng_last_d;
    if (out_load) begin
      send_q      <= rng_valid_q;
      first_q     <= rng_valid_q ? rng_first_q : '0;
      last_q      <= rng_valid_q ? rng_last_q : '0;
      resend_q    <= rng_valid_q && rng_resend_q;
      done_q      <= (base_q == last_p1);
      win_out_q   <= window_q;
      thr_out_q   <= threshold_q;
      phase_out_q <= phase_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.send_valid      = send_q;
  assign out_o.first_segment   = first_q;
  assign out_o.last_segment    = last_q;
  assign out_o.is_resend       = resend_q;
  assign out_o.transfer_done   = done_q;
  assign out_o.window_bytes    = win_out_q;
  assign out_o.threshold_bytes = thr_out_q;
  assign out_o.phase           = phase_out_q;

  reno_cwc_div #(
    .DividendBits (WindowBits),
    .DivisorBits  (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  `RCWC_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_fire, state_q != ST_IDLE)
  `RCWC_ASSERT_IMPL(a_div_done_awaited, clk_i, rst_ni, div_done, (state_q == ST_DIV_INC) || (state_q == ST_DIV_QUOT) || (state_q == ST_DIV_POLL))
  `RCWC_ASSERT_IMPL(a_idle_div_quiet, clk_i, rst_ni, state_q == ST_IDLE, !div_busy)
  `RCWC_ASSERT_IMPL(a_base_not_past_next, clk_i, rst_ni, 1'b1, base_q <= next_q)
  `RCWC_ASSERT_IMPL(a_wseg_nonzero, clk_i, rst_ni, 1'b1, wseg_q != '0)

endmodule

`default_nettype wire

[test/reno_congestion_window_control_tb.sv]
// Self-checking bench for the Reno congestion window controller: directed start, ACK, tick
// and poll sequences, then weighted random traffic over several register settings.
// Needs reno_cwc_pkg, reno_cwc_if and the controller RTL; results checked by a window tracker.
`default_nettype none

import reno_cwc_pkg::*;

typedef struct packed {
  logic                   send_valid;
  logic [SEQ_BITS-1:0]    first_seg;
  logic [SEQ_BITS-1:0]    last_seg;
  logic                   is_resend;
  logic                   done;
  logic [WINDOW_BITS-1:0] cwnd;
  logic [WINDOW_BITS-1:0] ssthresh;
  logic [1:0]             phase;
} seg_result_t;

class reno_window_tracker;
  logic [MSS_BITS-1:0]        seg_size;
  logic [THRESH_CFG_BITS-1:0] init_thresh;
  logic [COUNT_BITS-1:0]      seg_count;
  logic [TIMER_BITS-1:0]      rto_ticks;

  logic [WINDOW_BITS-1:0] cwnd;
  logic [WINDOW_BITS-1:0] ssthresh;
  logic [1:0]             dup_acks;
  phase_e                 cong_phase;
  logic [SEQ_BITS-1:0]    base;
  logic [SEQ_BITS-1:0]    next_seq;
  logic [SEQ_BITS-1:0]    wnd_segs;
  logic                   timer_on;
  logic [TIMER_BITS-1:0]  timer_ticks;

  seg_result_t pending_results[$];
  int mismatches;
  int results_seen;
  int op_count[4];
  int ranges_sent;
  int resends;
  int fast_recoveries;
  int timeouts;
  int saturations;

  function new();
    seg_size    = MSS_RESET;
    init_thresh = THRESH_RESET;
    seg_count   = COUNT_RESET;
    rto_ticks   = TIMEOUT_RESET;
    cwnd        = '0;
    ssthresh    = '0;
    dup_acks    = '0;
    cong_phase  = PH_SLOW_START;
    base        = 1;
    next_seq    = 1;
    wnd_segs    = 1;
    timer_on    = 1'b0;
    timer_ticks = '0;
  endfunction

  function void write_reg(reg_idx_e idx, logic [REG_DATA_BITS-1:0] value);
    case (idx)
      REG_SEGMENT_SIZE:  seg_size    = value[MSS_BITS-1:0];
      REG_INIT_THRESH:   init_thresh = value[THRESH_CFG_BITS-1:0];
      REG_SEGMENT_COUNT: seg_count   = value[COUNT_BITS-1:0];
      REG_TIMEOUT:       rto_ticks   = value[TIMER_BITS-1:0];
      default: ;
    endcase
  endfunction

  function longint unsigned mss();
    return (seg_size == 0) ? 64'd1 : 64'(seg_size);
  endfunction

  function logic [WINDOW_BITS-1:0] sat_window(longint unsigned v);
    longint unsigned lim;
    lim = (64'd1 << WINDOW_BITS) - 1;
    if (v > lim) begin
      saturations++;
      return lim[WINDOW_BITS-1:0];
    end
    return v[WINDOW_BITS-1:0];
  endfunction

  function longint unsigned final_segment();
    longint unsigned lim;
    lim = (64'd1 << SEQ_BITS) - 2;
    return (64'(seg_count) > lim) ? lim : 64'(seg_count);
  endfunction

  // cwnd in whole segments, never zero
  function logic [SEQ_BITS-1:0] window_quotient();
    longint unsigned q;
    q = 64'(cwnd) / mss();
    if (q == 0) q = 1;
    if (q > (64'd1 << SEQ_BITS) - 1) q = (64'd1 << SEQ_BITS) - 1;
    return q[SEQ_BITS-1:0];
  endfunction

  function void apply_item(op_e op, logic [SEQ_BITS-1:0] ack, logic good);
    seg_result_t r;
    bit resend_all;
    longint unsigned m;
    longint unsigned n;
    longint unsigned top;
    r = '0;
    resend_all = 1'b0;
    m = mss();
    op_count[int'(op)]++;
    case (op)
      OP_START: begin
        cwnd        = sat_window(m);
        ssthresh    = init_thresh;
        dup_acks    = '0;
        cong_phase  = PH_SLOW_START;
        base        = 1;
        next_seq    = 1;
        wnd_segs    = 1;
        timer_on    = 1'b0;
        timer_ticks = '0;
      end
      OP_ACK: begin
        if (good && ack >= base && ack < next_seq) begin
          case (cong_phase)
            PH_AVOIDANCE: begin
              n = (wnd_segs == 0) ? 64'd1 : 64'(wnd_segs);
              cwnd = sat_window(64'(cwnd) + m / n);
            end
            PH_RECOVERY: begin
              cwnd = ssthresh;
              cong_phase = PH_AVOIDANCE;
            end
            default: begin
              cwnd = sat_window(64'(cwnd) + m);
              cong_phase = (cwnd >= ssthresh) ? PH_AVOIDANCE : PH_SLOW_START;
            end
          endcase
          dup_acks    = '0;
          wnd_segs    = window_quotient();
          base        = ack + 1'b1;
          timer_ticks = '0;
          timer_on    = (base != next_seq);
        end else if (good && ack < base) begin
          if (cong_phase == PH_RECOVERY) begin
            cwnd = sat_window(64'(cwnd) + m);
          end else if (dup_acks < DUP_LIMIT) begin
            dup_acks++;
            if (dup_acks == DUP_LIMIT) begin
              ssthresh    = cwnd >> 1;
              cwnd        = sat_window(64'(ssthresh) + 3 * m);
              cong_phase  = PH_RECOVERY;
              timer_ticks = '0;
              resend_all  = 1'b1;
              fast_recoveries++;
            end
          end
        end
      end
      OP_TICK: begin
        if (timer_on) begin
          if (timer_ticks != '1) timer_ticks++;
          if (timer_ticks >= rto_ticks) begin
            ssthresh    = cwnd >> 1;
            cwnd        = sat_window(m);
            dup_acks    = '0;
            cong_phase  = PH_SLOW_START;
            timer_ticks = '0;
            resend_all  = 1'b1;
            timeouts++;
          end
        end
      end
      default: begin
        wnd_segs = window_quotient();
        top = 64'(base) + 64'(wnd_segs) - 1;
        if (top > final_segment()) top = final_segment();
        if (64'(next_seq) <= top) begin
          r.send_valid = 1'b1;
          r.first_seg  = next_seq;
          r.last_seg   = top[SEQ_BITS-1:0];
          if (!timer_on && base == next_seq) begin
            timer_on    = 1'b1;
            timer_ticks = '0;
          end
          next_seq = top[SEQ_BITS-1:0] + 1'b1;
        end
      end
    endcase

    if (resend_all && base < next_seq) begin
      r.send_valid = 1'b1;
      r.is_resend  = 1'b1;
      r.first_seg  = base;
      r.last_seg   = next_seq - 1'b1;
      resends++;
    end
    if (r.send_valid) ranges_sent++;
    r.done     = (64'(base) == final_segment() + 1);
    r.cwnd     = cwnd;
    r.ssthresh = ssthresh;
    r.phase    = cong_phase;
    pending_results.push_back(r);
  endfunction

  function string fmt(seg_result_t r);
    return $sformatf("send=%0b %0d..%0d resend=%0b done=%0b cwnd=%0d ssthresh=%0d phase=%0d",
                     r.send_valid, r.first_seg, r.last_seg, r.is_resend, r.done,
                     r.cwnd, r.ssthresh, r.phase);
  endfunction

  function void compare_result(seg_result_t got);
    seg_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with nothing outstanding: %s", fmt(got));
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d differs\n  expected %s\n  actual   %s",
                 results_seen, fmt(want), fmt(got));
    end
  endfunction
endclass

module reno_congestion_window_control_tb;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [REG_ADDR_BITS-1:0] paddr;
  logic [REG_DATA_BITS-1:0] pwdata;
  logic [REG_DATA_BITS-1:0] prdata;
  logic                     pready;

  reno_cwc_in_if  in_ch ();
  reno_cwc_out_if out_ch ();

  reno_window_tracker tracker;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int idle_cycles     = 0;

  reno_congestion_window_control dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // no transaction on either channel for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    seg_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.send_valid = out_ch.send_valid;
        got.first_seg  = out_ch.first_segment;
        got.last_seg   = out_ch.last_segment;
        got.is_resend  = out_ch.is_resend;
        got.done       = out_ch.transfer_done;
        got.cwnd       = out_ch.window_bytes;
        got.ssthresh   = out_ch.threshold_bytes;
        got.phase      = out_ch.phase;
        tracker.compare_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // call in step with the clock; returns when the DUT accepts the item
  task automatic push_item(input op_e op, input logic [SEQ_BITS-1:0] ack, input logic good);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.ack_number <= ack;
    in_ch.ack_good   <= good;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.apply_item(op, ack, good);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [REG_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [MSS_BITS-1:0] mss_v,
                            input logic [THRESH_CFG_BITS-1:0] thr_v,
                            input logic [COUNT_BITS-1:0] cnt_v,
                            input logic [TIMER_BITS-1:0] rto_v);
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    reg_write(REG_SEGMENT_SIZE, REG_DATA_BITS'(mss_v));
    reg_write(REG_INIT_THRESH, REG_DATA_BITS'(thr_v));
    reg_write(REG_SEGMENT_COUNT, REG_DATA_BITS'(cnt_v));
    reg_write(REG_TIMEOUT, REG_DATA_BITS'(rto_v));
  endtask

  // ACK inside the flight window, mostly the oldest segment; a poll when nothing is in flight
  task automatic send_fresh_ack();
    logic [SEQ_BITS-1:0] ack;
    if (tracker.base < tracker.next_seq) begin
      if ($urandom_range(1)) ack = tracker.base;
      else ack = SEQ_BITS'($urandom_range(tracker.next_seq - 1, tracker.base));
      push_item(OP_ACK, ack, 1'b1);
    end else begin
      push_item(OP_POLL, SEQ_BITS'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_traffic(input int items, input int w_start, input int w_ack,
                             input int w_dup, input int w_tick, input int w_poll,
                             input int w_noise);
    int issued;
    int pick;
    logic [SEQ_BITS-1:0] ack;
    issued = 0;
    push_item(OP_START, SEQ_BITS'($urandom), 1'($urandom));
    while (issued < items) begin
      pick = $urandom_range(w_start + w_ack + w_dup + w_tick + w_poll + w_noise - 1);
      ack  = SEQ_BITS'($urandom);
      if (pick >= w_start + w_ack + w_dup + w_tick + w_poll) begin
        if ($urandom_range(1)) push_item(OP_ACK, ack, 1'b0);
        else push_item(OP_ACK, SEQ_BITS'($urandom_range((1 << SEQ_BITS) - 1,
                                                        tracker.next_seq)), 1'b1);
      end else begin
        if (pick < w_start) begin
          push_item(OP_START, ack, 1'($urandom));
        end else if (pick < w_start + w_ack) begin
          send_fresh_ack();
        end else if (pick < w_start + w_ack + w_dup) begin
          if (tracker.base > 1) begin
            if ($urandom_range(1)) ack = tracker.base - 1'b1;
            else ack = SEQ_BITS'($urandom_range(tracker.base - 1, 0));
            push_item(OP_ACK, ack, 1'b1);
          end else begin
            send_fresh_ack();
          end
        end else if (pick < w_start + w_ack + w_dup + w_tick) begin
          push_item(OP_TICK, ack, 1'($urandom));
        end else begin
          push_item(OP_POLL, ack, 1'($urandom));
        end
        issued++;
      end
    end
  endtask

  initial begin
    tracker = new();
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_START;
    in_ch.ack_number <= '0;
    in_ch.ack_good   <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before any start: reset window of zero
    push_item(OP_POLL, 16'h0000, 1'b0);
    push_item(OP_ACK, 16'h0000, 1'b1);
    set_config(MSS_RESET, THRESH_RESET, 16'd5, TIMEOUT_RESET);
    push_item(OP_POLL, 16'hFFFF, 1'b1);

    // one short transfer through every phase
    set_config(16'd1000, 24'd3000, 16'd6, 32'd2);
    push_item(OP_START, 16'h0000, 1'b0);
    push_item(OP_POLL, 16'h0000, 1'b0);
    push_item(OP_ACK, 16'd1, 1'b1);
    push_item(OP_POLL, 16'h0000, 1'b0);
    push_item(OP_ACK, 16'hFFFF, 1'b1);
    push_item(OP_ACK, 16'd2, 1'b0);
    push_item(OP_ACK, 16'd2, 1'b1);
    push_item(OP_POLL, 16'h0000, 1'b0);
    repeat (4) push_item(OP_ACK, 16'd0, 1'b1);
    push_item(OP_ACK, 16'd3, 1'b1);
    push_item(OP_ACK, 16'd4, 1'b1);
    repeat (2) push_item(OP_TICK, 16'h0000, 1'b0);
    push_item(OP_ACK, 16'd5, 1'b1);
    push_item(OP_POLL, 16'h0000, 1'b0);
    push_item(OP_ACK, 16'd6, 1'b1);
    push_item(OP_POLL, 16'h0000, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b0);
    repeat (3) push_item(OP_ACK, 16'd0, 1'b1);

    set_config(16'd1000, 24'd8000, 16'd300, 32'd5);
    sender_idle_pct = 0;
    stall_pct = 0;
    run_traffic(250, 3, 30, 15, 15, 30, 7);

    set_config(16'd1, 24'd0, 16'd65534, 32'd1);
    sender_idle_pct = 75;
    stall_pct = 0;
    run_traffic(210, 3, 30, 15, 15, 30, 7);

    set_config(16'd1460, 24'd20000, 16'd40, 32'd8);
    sender_idle_pct = 0;
    stall_pct = 75;
    run_traffic(210, 3, 30, 15, 15, 30, 7);

    // fast recovery held open long enough to saturate cwnd
    set_config(16'd65535, 24'hFFFFFF, 16'd400, 32'hFFFF_FFFF);
    sender_idle_pct = 27;
    stall_pct = 27;
    run_traffic(350, 0, 0, 85, 5, 5, 5);

    set_config(16'd536, 24'd4000, 16'd1, 32'd3);
    sender_idle_pct = 0;
    stall_pct = 0;
    run_traffic(130, 3, 30, 15, 15, 30, 7);

    set_config(MSS_BITS'($urandom_range(4000, 1)), THRESH_CFG_BITS'($urandom),
               COUNT_BITS'($urandom_range(500, 1)), TIMER_BITS'($urandom_range(12, 1)));
    sender_idle_pct = 27;
    stall_pct = 27;
    run_traffic(260, 3, 30, 15, 15, 30, 7);

    set_config(16'd512, 24'd3000, 16'd120, 32'd6);
    sender_idle_pct = 75;
    stall_pct = 0;
    run_traffic(210, 3, 30, 15, 15, 30, 7);

    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d results: %0d starts, %0d ACKs, %0d ticks, %0d polls, %0d ranges sent",
             tracker.results_seen, tracker.op_count[OP_START], tracker.op_count[OP_ACK],
             tracker.op_count[OP_TICK], tracker.op_count[OP_POLL], tracker.ranges_sent);
    $display("Resends %0d, fast recoveries %0d, timeouts %0d, saturated updates %0d, mismatches %0d",
             tracker.resends, tracker.fast_recoveries, tracker.timeouts,
             tracker.saturations, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
